### rtl/slmr_pkg.sv
`default_nettype none
package slmr_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int IP_W      = 32;
  localparam int MAC_W     = 48;
  localparam int DIR_W     = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 48;

  localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
  localparam logic [DIR_W-1:0] DIR_IN   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_OUT  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC        = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GATEWAY_MAC    = 8'd3;

  // search record handed from cell to cell
  typedef struct packed {
    logic             act;
    logic [IP_W-1:0]  key;
    logic             hit;
    logic [MAC_W-1:0] mac;
  } search_t;

  // table write from the controller into the chain
  typedef struct packed {
    logic             en;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
  } table_wr_t;

endpackage
`default_nettype wire

### rtl/slmr_if.sv
`default_nettype none
interface slmr_in_if;
  logic                      valid;
  logic                      ready;
  logic [slmr_pkg::IP_W-1:0]  source_ip;
  logic [slmr_pkg::IP_W-1:0]  dest_ip;
  logic [slmr_pkg::MAC_W-1:0] source_mac;

  modport source (output valid, output source_ip, output dest_ip, output source_mac,
                  input ready);
  modport sink   (input valid, input source_ip, input dest_ip, input source_mac,
                  output ready);
endinterface

interface slmr_out_if;
  logic                       valid;
  logic                       ready;
  logic                       forward;
  logic [slmr_pkg::DIR_W-1:0] direction;
  logic [slmr_pkg::MAC_W-1:0] new_source_mac;
  logic [slmr_pkg::MAC_W-1:0] new_dest_mac;
  logic                       learned;
  logic                       learn_failed;

  modport source (output valid, output forward, output direction, output new_source_mac,
                  output new_dest_mac, output learned, output learn_failed,
                  input ready);
  modport sink   (input valid, input forward, input direction, input new_source_mac,
                  input new_dest_mac, input learned, input learn_failed,
                  output ready);
endinterface

interface slmr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [slmr_pkg::CFG_IDX_W-1:0] index;
  logic [slmr_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/slmr_cell.sv
`default_nettype none
module slmr_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire slmr_pkg::search_t   link_i,
  output slmr_pkg::search_t        link_o,
  input  wire slmr_pkg::table_wr_t wr_i
);

  logic                       valid_r;
  logic [slmr_pkg::IP_W-1:0]  ip_r;
  logic [slmr_pkg::MAC_W-1:0] mac_r;
  slmr_pkg::search_t          link_r, link_nxt;
  logic                       match;

  // only the first matching cell claims the request
  assign match = link_i.act && !link_i.hit && valid_r && (ip_r == link_i.key);

  always_comb begin
    link_nxt = link_i;
    if (match) begin
      link_nxt.hit = 1'b1;
      link_nxt.mac = mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      link_r  <= '0;
    end else begin
      link_r <= link_nxt;
      if (wr_i.en) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_i.en) begin
      ip_r  <= wr_i.ip;
      mac_r <= wr_i.mac;
    end
  end

  assign link_o = link_r;

endmodule
`default_nettype wire

### rtl/slmr_chain.sv
`default_nettype none
module slmr_chain #(
  parameter int TABLE_ENTRIES = slmr_pkg::TABLE_ENTRIES_DEF,
  parameter int CW            = $clog2(TABLE_ENTRIES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire slmr_pkg::search_t   head_i,
  output slmr_pkg::search_t        tail_o,
  input  wire slmr_pkg::table_wr_t wr_i,
  input  wire logic [CW-1:0]      wr_idx_i
);

  slmr_pkg::search_t link [TABLE_ENTRIES+1];

  assign link[0] = head_i;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    slmr_pkg::table_wr_t cell_wr;

    // steer the write to the cell at the fill position
    always_comb begin
      cell_wr    = wr_i;
      cell_wr.en = wr_i.en && (wr_idx_i == CW'(i));
    end

    slmr_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .wr_i   (cell_wr)
    );
  end

  assign tail_o = link[TABLE_ENTRIES];

endmodule
`default_nettype wire

### rtl/subnet_learning_mac_rewriter_unit.sv
`default_nettype none
// Channel | Dir | Fields                                          | Request moves
// in_if   | in  | source_ip, dest_ip, source_mac                  | one packet header
// out_if  | out | forward, direction, new_source_mac,             | one rewrite result
//         |     | new_dest_mac, learned, learn_failed             |
// cfg_if  | in  | index, data                                     | one register write
//
// A header that needs a table lookup walks the cell chain, one cell a cycle;
// an off-net header skips the chain and goes to the result stage without a search.
// One header is in flight at a time; the next is taken once the result sits
// in the output register, even while that result is stalled.
// Reset (rst_n, synchronous) clears all entry valid bits, the fill count and
// the registers at once; no clearing pass is needed.
module subnet_learning_mac_rewriter_unit #(
  parameter int TABLE_ENTRIES = slmr_pkg::TABLE_ENTRIES_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  slmr_in_if.sink     in_if,
  slmr_out_if.source  out_if,
  slmr_cfg_if.sink    cfg_if
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [slmr_pkg::DIR_W-1:0] mode_r;
  logic [slmr_pkg::IP_W-1:0]  key_r;
  logic [slmr_pkg::MAC_W-1:0] src_mac_r;
  logic                       hit_r;
  logic [slmr_pkg::MAC_W-1:0] hit_mac_r;
  logic [CW-1:0]              count_r;

  logic [slmr_pkg::IP_W-1:0]  subnet_address_r;
  logic [slmr_pkg::IP_W-1:0]  subnet_mask_r;
  logic [slmr_pkg::MAC_W-1:0] own_mac_r;
  logic [slmr_pkg::MAC_W-1:0] gateway_mac_r;

  logic                       out_valid_r;
  logic                       out_forward_r;
  logic [slmr_pkg::DIR_W-1:0] out_direction_r;
  logic [slmr_pkg::MAC_W-1:0] out_src_mac_r;
  logic [slmr_pkg::MAC_W-1:0] out_dst_mac_r;
  logic                       out_learned_r;
  logic                       out_failed_r;

  logic                       accept, dst_local, src_local, commit, full;
  logic                       learn_ok, learn_fail;
  logic [slmr_pkg::DIR_W-1:0] mode_in;
  slmr_pkg::search_t          head, tail;
  slmr_pkg::table_wr_t        wr;

  // ---- configuration ----
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subnet_address_r <= '0;
      subnet_mask_r    <= '0;
      own_mac_r        <= '0;
      gateway_mac_r    <= '0;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        slmr_pkg::CFG_SUBNET_ADDRESS: subnet_address_r <= cfg_if.data[slmr_pkg::IP_W-1:0];
        slmr_pkg::CFG_SUBNET_MASK:    subnet_mask_r    <= cfg_if.data[slmr_pkg::IP_W-1:0];
        slmr_pkg::CFG_OWN_MAC:        own_mac_r        <= cfg_if.data;
        slmr_pkg::CFG_GATEWAY_MAC:    gateway_mac_r    <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // ---- classify the header ----
  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign dst_local   = (in_if.dest_ip & subnet_mask_r) == subnet_address_r;
  assign src_local   = (in_if.source_ip & subnet_mask_r) == subnet_address_r;

  // destination wins when both sides are local
  always_comb begin
    if (dst_local) begin
      mode_in = slmr_pkg::DIR_IN;
    end else if (src_local) begin
      mode_in = slmr_pkg::DIR_OUT;
    end else begin
      mode_in = slmr_pkg::DIR_NONE;
    end
  end

  always_comb begin
    head.act = accept && (mode_in != slmr_pkg::DIR_NONE);
    head.key = dst_local ? in_if.dest_ip : in_if.source_ip;
    head.hit = 1'b0;
    head.mac = '0;
  end

  // ---- commit: learn and load the result ----
  assign commit     = (state_r == ST_FINISH) && (!out_valid_r || out_if.ready);
  assign full       = (count_r == CW'(TABLE_ENTRIES));
  assign learn_ok   = (mode_r == slmr_pkg::DIR_OUT) && !hit_r && !full;
  assign learn_fail = (mode_r == slmr_pkg::DIR_OUT) && !hit_r && full;

  always_comb begin
    wr.en  = commit && learn_ok;
    wr.ip  = key_r;
    wr.mac = src_mac_r;
  end

  slmr_chain #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .CW            (CW)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_i   (head),
    .tail_o   (tail),
    .wr_i     (wr),
    .wr_idx_i (count_r)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (mode_in == slmr_pkg::DIR_NONE) ? ST_FINISH : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (tail.act) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wr.en) begin
        count_r <= count_r + CW'(1);
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r    <= mode_in;
      key_r     <= head.key;
      src_mac_r <= in_if.source_mac;
      hit_r     <= 1'b0;
    end
    if ((state_r == ST_SEARCH) && tail.act) begin
      hit_r     <= tail.hit;
      hit_mac_r <= tail.mac;
    end
    if (commit) begin
      out_learned_r <= learn_ok;
      out_failed_r  <= learn_fail;
      case (mode_r)
        slmr_pkg::DIR_IN: begin
          out_forward_r   <= hit_r;
          out_direction_r <= hit_r ? slmr_pkg::DIR_IN : slmr_pkg::DIR_NONE;
          out_src_mac_r   <= hit_r ? own_mac_r : '0;
          out_dst_mac_r   <= hit_r ? hit_mac_r : '0;
        end
        slmr_pkg::DIR_OUT: begin
          out_forward_r   <= 1'b1;
          out_direction_r <= slmr_pkg::DIR_OUT;
          out_src_mac_r   <= own_mac_r;
          out_dst_mac_r   <= gateway_mac_r;
        end
        default: begin
          out_forward_r   <= 1'b0;
          out_direction_r <= slmr_pkg::DIR_NONE;
          out_src_mac_r   <= '0;
          out_dst_mac_r   <= '0;
        end
      endcase
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.forward        = out_forward_r;
  assign out_if.direction      = out_direction_r;
  assign out_if.new_source_mac = out_src_mac_r;
  assign out_if.new_dest_mac   = out_dst_mac_r;
  assign out_if.learned        = out_learned_r;
  assign out_if.learn_failed   = out_failed_r;

  // ---- checks ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES))
    else $error("fill count beyond table size");

  a_learn_advances: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> count_r == $past(count_r) + CW'(1))
    else $error("learning did not advance the fill count");

  a_learn_outbound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_learned_r || out_failed_r)) |->
      (out_forward_r && out_direction_r == slmr_pkg::DIR_OUT &&
       !(out_learned_r && out_failed_r)))
    else $error("learn flags on a result that is not outbound");

  a_tail_only_searching: assert property (@(posedge clk) disable iff (!rst_n)
    tail.act |-> state_r == ST_SEARCH)
    else $error("search request left the chain outside a search");

endmodule
`default_nettype wire

### sim/slmr_rewrite_checker.sv
`timescale 1ns / 100ps
module slmr_rewrite_checker
  import slmr_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  slmr_in_if   in_if,
  slmr_out_if  out_if,
  slmr_cfg_if  cfg_if,
  output int   fail_count,
  output int   pending,
  output int   inbound_seen,
  output int   outbound_seen,
  output int   dropped_seen,
  output int   learned_seen,
  output int   refused_seen
);

  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef struct packed {
    logic             forward;
    logic [DIR_W-1:0] direction;
    logic [MAC_W-1:0] new_source_mac;
    logic [MAC_W-1:0] new_dest_mac;
    logic             learned;
    logic             learn_failed;
  } rewrite_t;

  rewrite_t expected_rewrites[$];

  logic [IP_W-1:0]   net_addr;
  logic [IP_W-1:0]   net_mask;
  logic [MAC_W-1:0]  own_mac;
  logic [MAC_W-1:0]  gateway_mac;
  logic [IP_W-1:0]   client_ip  [TABLE_ENTRIES];
  logic [MAC_W-1:0]  client_mac [TABLE_ENTRIES];
  logic              slot_used  [TABLE_ENTRIES];
  logic [FILL_W-1:0] slots_filled;

  function automatic logic on_subnet(input logic [IP_W-1:0] ip);
    return (ip & net_mask) == net_addr;
  endfunction

  function automatic int find_client(input logic [IP_W-1:0] ip);
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      if (slot_used[k] && client_ip[k] == ip) return k;
    end
    return -1;
  endfunction

  // destination lookup wins over source learning when both are on the subnet
  function automatic rewrite_t rewrite_header(input logic [IP_W-1:0] sip,
                                              input logic [IP_W-1:0] dip,
                                              input logic [MAC_W-1:0] smac);
    rewrite_t r;
    int       slot;
    r = '0;
    if (on_subnet(dip)) begin
      slot = find_client(dip);
      if (slot >= 0) begin
        r.forward        = 1'b1;
        r.direction      = DIR_IN;
        r.new_source_mac = own_mac;
        r.new_dest_mac   = client_mac[slot];
      end
    end else if (on_subnet(sip)) begin
      if (find_client(sip) < 0) begin
        if (slots_filled < TABLE_ENTRIES) begin
          client_ip[slots_filled[IDX_W-1:0]]  = sip;
          client_mac[slots_filled[IDX_W-1:0]] = smac;
          slot_used[slots_filled[IDX_W-1:0]]  = 1'b1;
          slots_filled                        = slots_filled + FILL_W'(1);
          r.learned                           = 1'b1;
        end else begin
          r.learn_failed = 1'b1;
        end
      end
      r.forward        = 1'b1;
      r.direction      = DIR_OUT;
      r.new_source_mac = own_mac;
      r.new_dest_mac   = gateway_mac;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rewrite_t got;
    rewrite_t want;
    if (!rst_n) begin
      net_addr     = '0;
      net_mask     = '0;
      own_mac      = '0;
      gateway_mac  = '0;
      slots_filled = '0;
      for (int k = 0; k < TABLE_ENTRIES; k++) slot_used[k] = 1'b0;
      expected_rewrites.delete();
      fail_count    = 0;
      inbound_seen  = 0;
      outbound_seen = 0;
      dropped_seen  = 0;
      learned_seen  = 0;
      refused_seen  = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          CFG_SUBNET_ADDRESS: net_addr    = cfg_if.data[IP_W-1:0];
          CFG_SUBNET_MASK:    net_mask    = cfg_if.data[IP_W-1:0];
          CFG_OWN_MAC:        own_mac     = cfg_if.data[MAC_W-1:0];
          CFG_GATEWAY_MAC:    gateway_mac = cfg_if.data[MAC_W-1:0];
          default: ;  // drop writes to unmapped indexes
        endcase
      end
      if (in_if.valid && in_if.ready)
        expected_rewrites.push_back(rewrite_header(in_if.source_ip, in_if.dest_ip,
                                                   in_if.source_mac));
      if (out_if.valid && out_if.ready) begin
        got = {out_if.forward, out_if.direction, out_if.new_source_mac,
               out_if.new_dest_mac, out_if.learned, out_if.learn_failed};
        if (expected_rewrites.size() == 0) begin
          $display("%0t: result with no header outstanding, expected none, got %h",
                   $time, got);
          fail_count++;
        end else begin
          want = expected_rewrites.pop_front();
          check_field("forward", MAC_W'(want.forward), MAC_W'(got.forward));
          check_field("direction", MAC_W'(want.direction), MAC_W'(got.direction));
          check_field("new_source_mac", want.new_source_mac, got.new_source_mac);
          check_field("new_dest_mac", want.new_dest_mac, got.new_dest_mac);
          check_field("learned", MAC_W'(want.learned), MAC_W'(got.learned));
          check_field("learn_failed", MAC_W'(want.learn_failed),
                      MAC_W'(got.learn_failed));
          case (want.direction)
            DIR_IN:  inbound_seen++;
            DIR_OUT: outbound_seen++;
            default: dropped_seen++;
          endcase
          learned_seen += want.learned;
          refused_seen += want.learn_failed;
        end
      end
    end
    pending = expected_rewrites.size();
  end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
module tb;
  import slmr_pkg::*;

  localparam int TABLE_ENTRIES = TABLE_ENTRIES_DEF;
  localparam int STALL_LIMIT   = 4000;
  localparam int LONG_HOLD     = 400;
  localparam int PROFILE_LEN   = 50;

  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

  localparam logic [IP_W-1:0] HOME_NET   = 32'hC0A8_0100;
  localparam logic [IP_W-1:0] HOME_MASK  = 32'hFFFF_FF00;
  localparam logic [IP_W-1:0] WIDE_NET   = 32'h0A00_0000;
  localparam logic [IP_W-1:0] WIDE_MASK  = 32'hFF00_0000;
  localparam logic [IP_W-1:0] CLIENT_A   = 32'hC0A8_010A;
  localparam logic [IP_W-1:0] CLIENT_B   = 32'hC0A8_010B;
  localparam logic [IP_W-1:0] HOST_FIRST = 32'hC0A8_0100;
  localparam logic [IP_W-1:0] HOST_LAST  = 32'hC0A8_01FF;
  localparam logic [IP_W-1:0] REMOTE_A   = 32'h0808_0808;
  localparam logic [IP_W-1:0] REMOTE_B   = 32'h0101_0101;

  logic clk;
  logic rst_n;

  slmr_in_if  hdr_if ();
  slmr_out_if res_if ();
  slmr_cfg_if reg_if ();

  int fail_count;
  int pending;
  int inbound_seen;
  int outbound_seen;
  int dropped_seen;
  int learned_seen;
  int refused_seen;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_cycles    = 0;
  int quiet_cycles   = 0;
  int headers_sent   = 0;
  int settings_used  = 0;

  logic [IP_W-1:0] net_addr;
  logic [IP_W-1:0] net_mask;
  logic [IP_W-1:0] client_pool[$];

  subnet_learning_mac_rewriter_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (hdr_if),
    .out_if (res_if),
    .cfg_if (reg_if)
  );

  slmr_rewrite_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_rewrite_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_if         (hdr_if),
    .out_if        (res_if),
    .cfg_if        (reg_if),
    .fail_count    (fail_count),
    .pending       (pending),
    .inbound_seen  (inbound_seen),
    .outbound_seen (outbound_seen),
    .dropped_seen  (dropped_seen),
    .learned_seen  (learned_seen),
    .refused_seen  (refused_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (hdr_if.valid && hdr_if.ready) || (res_if.valid && res_if.ready) ||
        (reg_if.valid && reg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold-off when asked for
  initial begin : result_sink
    int held;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        res_if.ready <= 1'b0;
        for (held = 1; held < hold_cycles; held++) @(negedge clk);
        hold_cycles = 0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic on_net(input logic [IP_W-1:0] ip);
    return (ip & net_mask) == net_addr;
  endfunction

  function automatic logic [IP_W-1:0] local_ip();
    return (net_addr & net_mask) | ($urandom & ~net_mask);
  endfunction

  // flip the lowest mask bit to push a random address off the subnet
  function automatic logic [IP_W-1:0] remote_ip();
    logic [IP_W-1:0] ip;
    ip = $urandom;
    if (on_net(ip)) ip = ip ^ (net_mask & (~net_mask + IP_W'(1)));
    return ip;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  task automatic offer_header(input logic [IP_W-1:0] sip, input logic [IP_W-1:0] dip,
                              input logic [MAC_W-1:0] smac);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      hdr_if.valid <= 1'b0;
      @(negedge clk);
    end
    hdr_if.valid      <= 1'b1;
    hdr_if.source_ip  <= sip;
    hdr_if.dest_ip    <= dip;
    hdr_if.source_mac <= smac;
    @(posedge clk);
    while (!hdr_if.ready) @(posedge clk);
    headers_sent++;
  endtask

  // lower valid and hold until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk);
    hdr_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    reg_if.valid <= 1'b1;
    reg_if.index <= idx;
    reg_if.data  <= value;
    @(posedge clk);
    while (!reg_if.ready) @(posedge clk);
    @(negedge clk);
    reg_if.valid <= 1'b0;
  endtask

  task automatic configure(input logic [IP_W-1:0] addr, input logic [IP_W-1:0] mask,
                           input logic [MAC_W-1:0] own, input logic [MAC_W-1:0] gw);
    wait_drained();
    write_reg(CFG_SUBNET_ADDRESS, CFG_DAT_W'(addr));
    write_reg(CFG_SUBNET_MASK, CFG_DAT_W'(mask));
    write_reg(CFG_OWN_MAC, own);
    write_reg(CFG_GATEWAY_MAC, gw);
    net_addr = addr;
    net_mask = mask;
    settings_used++;
  endtask

  task automatic random_header();
    logic [IP_W-1:0] sip;
    logic [IP_W-1:0] dip;
    int              pick;
    pick = $urandom_range(99);
    sip  = $urandom;
    dip  = $urandom;
    if (pick < 45) begin
      // outbound from a client; reuse a known one now and then
      sip = (client_pool.size() != 0 && $urandom_range(99) < 30) ?
            client_pool[$urandom_range(client_pool.size() - 1)] : local_ip();
      dip = remote_ip();
      if (on_net(sip) && client_pool.size() < TABLE_ENTRIES) client_pool.push_back(sip);
    end else if (pick < 75) begin
      dip = (client_pool.size() != 0 && $urandom_range(99) < 70) ?
            client_pool[$urandom_range(client_pool.size() - 1)] : local_ip();
      if ($urandom_range(1)) sip = local_ip();
    end else if (pick < 85) begin
      sip = local_ip();
      dip = local_ip();
    end
    offer_header(sip, dip, random_mac());
  endtask

  task automatic run_random(input int count, input logic pressure);
    int phase;
    for (int i = 0; i < count; i++) begin
      phase = (headers_sent / PROFILE_LEN) % 4;
      send_idle_pct  = (phase == 1) ? 58 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 58 : (phase == 3) ? 19 : 0;
      if (pressure && i == 120) begin
        send_idle_pct = 0;
        hold_cycles   = LONG_HOLD;
      end
      if (pressure && i == 260) wait_drained();
      random_header();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    hdr_if.valid      = 1'b0;
    hdr_if.source_ip  = '0;
    hdr_if.dest_ip    = '0;
    hdr_if.source_mac = '0;
    reg_if.valid      = 1'b0;
    reg_if.index      = '0;
    reg_if.data       = '0;
    net_addr          = '0;
    net_mask          = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // registers at reset: a zero mask makes every destination local, table empty
    offer_header('0, '0, '0);
    offer_header('1, '1, '1);

    configure(HOME_NET, HOME_MASK, '1, '0);
    write_reg(CFG_UNMAPPED, '1);
    offer_header(REMOTE_A, REMOTE_B, random_mac());
    offer_header(CLIENT_A, REMOTE_A, 48'h0200_0000_00A1);
    offer_header(CLIENT_A, REMOTE_B, 48'h0200_0000_00A2);
    offer_header(REMOTE_B, CLIENT_A, random_mac());
    offer_header(REMOTE_A, HOME_NET | 32'd99, random_mac());
    offer_header(CLIENT_B, CLIENT_A, 48'h0200_0000_00B1);
    offer_header(CLIENT_B, HOME_NET | 32'd200, random_mac());
    offer_header(HOST_FIRST, '1, '0);
    offer_header(HOST_LAST, '0, '1);
    offer_header(REMOTE_A, HOST_FIRST, random_mac());
    offer_header(REMOTE_A, HOST_LAST, random_mac());
    offer_header(CLIENT_B, REMOTE_A, 48'h0200_0000_00B2);
    offer_header('1, CLIENT_B, random_mac());
    client_pool = '{CLIENT_A, CLIENT_B, HOST_FIRST, HOST_LAST};

    // fill the table, then run on with it full
    configure(HOME_NET, HOME_MASK, random_mac(), random_mac());
    run_random(500, 1'b1);
    configure(CLIENT_A, '1, '0, '1);
    run_random(120, 1'b0);
    configure('0, '0, random_mac(), random_mac());
    run_random(150, 1'b0);
    // address bits outside the mask: nothing is local
    configure('1, '0, random_mac(), random_mac());
    run_random(60, 1'b0);
    configure(WIDE_NET, WIDE_MASK, random_mac(), random_mac());
    run_random(60, 1'b0);
    configure(HOME_NET, HOME_MASK, random_mac(), random_mac());
    run_random(60, 1'b0);

    wait_drained();
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    $display("Ran %0d headers over %0d subnet settings: %0d inbound, %0d outbound, %0d dropped",
             headers_sent, settings_used, inbound_seen, outbound_seen, dropped_seen);
    $display("Client table took %0d entries and refused %0d once full",
             learned_seen, refused_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
